@@ rtl/core/csvp_pkg.sv @@
// Shared types, character codes and constants for the CSV decimal field parser.
// No dependencies; every other file imports this package.
`default_nettype none

package csvp_pkg;

   // character codes
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_DOT   = 8'd46;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;

   localparam int FRAC_BITS_DEFAULT  = 32;
   localparam int MAX_FIELDS_DEFAULT = 16;

   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 4;
   localparam int VALUE_W  = 64;
   localparam int FPL_W    = 5;
   localparam int DIGIT_W  = 4;
   localparam int NDIG_W   = 4;

   localparam logic [FPL_W-1:0]   FPL_RESET     = 5'd11;
   localparam logic [31:0]        WHOLE_MAX     = 32'h7FFF_FFFF;
   localparam logic [NDIG_W-1:0]  NDIG_LAST     = 4'd9;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_FIELDS_PER_LINE = 1'b0;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_BAD_CHAR = 2'd1,
      ERR_SYNTAX   = 2'd2,
      ERR_COUNT    = 2'd3
   } err_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        field_index;
      logic signed [VALUE_W-1:0] field_value;
      logic                      end_of_line;
      err_type                   error_code;
   } result_type;

   // Weight of the next fraction digit: floor(2^32 / 10^(n+1)).
   function automatic logic [31:0] digit_weight(input logic [NDIG_W-1:0] n);
      logic [31:0] w;
      unique case (n)
         4'd0:    w = 32'd429496729;
         4'd1:    w = 32'd42949672;
         4'd2:    w = 32'd4294967;
         4'd3:    w = 32'd429496;
         4'd4:    w = 32'd42949;
         4'd5:    w = 32'd4294;
         4'd6:    w = 32'd429;
         4'd7:    w = 32'd42;
         4'd8:    w = 32'd4;
         default: w = 32'd0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/csvp_csr.sv @@
// APB-style configuration register block: holds fields_per_line.
// Depends on csvp_pkg.
`default_nettype none

module csvp_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [csvp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [csvp_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [csvp_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready,
   output logic      [csvp_pkg::FPL_W-1:0]       fields_per_line
);
   import csvp_pkg::*;

   logic [FPL_W-1:0] fpl_ff;
   logic [FPL_W-1:0] fpl_in;
   logic             reg_idx;

   assign reg_idx = paddr[2];
   assign pready  = 1'b1;

   always_comb begin
      fpl_in = fpl_ff;
      if (psel && penable && pwrite && pready && (reg_idx == CSR_IDX_FIELDS_PER_LINE)) begin
         fpl_in = pwdata[FPL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fpl_ff <= FPL_RESET;
      end else begin
         fpl_ff <= fpl_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == CSR_IDX_FIELDS_PER_LINE) begin
         prdata = CSR_DATA_W'(fpl_ff);
      end
   end

   assign fields_per_line = fpl_ff;

endmodule

`default_nettype wire

@@ rtl/core/csvp_field_accum.sv @@
// Per-byte field state: digit accumulation, error tracking, field counting,
// and formation of the closed field's fixed-point result. Depends on csvp_pkg.
`default_nettype none

module csvp_field_accum #(
   parameter int FRAC_BITS  = csvp_pkg::FRAC_BITS_DEFAULT,
   parameter int MAX_FIELDS = csvp_pkg::MAX_FIELDS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [csvp_pkg::BYTE_W-1:0]   byte_in,
   input  wire logic                          advance,
   input  wire logic [csvp_pkg::FPL_W-1:0]    fields_per_line,
   output logic                               emit,
   output csvp_pkg::result_type               result
);
   import csvp_pkg::*;

   logic [31:0]         whole_ff,  whole_in;
   logic [31:0]         frac_ff,   frac_in;
   logic [NDIG_W-1:0]   ndig_ff,   ndig_in;
   logic                neg_ff,    neg_in;
   logic                dot_ff,    dot_in;
   logic [INDEX_W-1:0]  cnt_ff,    cnt_in;
   logic                chars_ff,  chars_in;
   logic                lhb_ff,    lhb_in;
   err_type             pend_ff,   pend_in;
   logic                ovf_ff,    ovf_in;

   logic                is_digit, is_delim, eol;
   logic [DIGIT_W-1:0]  digit;
   logic [31:0]         weight;
   logic [35:0]         prod, frac_sum, whole_sum;
   logic [FPL_W-1:0]    cnt_p1;
   logic                count_bad;
   err_type             err_out;
   logic [VALUE_W-1:0]  mag;

   assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
   assign is_delim = (byte_in == CH_LF) || (byte_in == CH_NUL) || (byte_in == CH_COMMA);
   assign eol      = (byte_in != CH_COMMA);
   assign digit    = DIGIT_W'(byte_in - CH_ZERO);
   // a line end on an empty line produces nothing
   assign emit     = is_delim && !(eol && !lhb_ff);

   assign weight = digit_weight(ndig_ff);
   // digit * weight as shift-add, digit is at most 9
   assign prod = ({4'b0, weight} & {36{digit[0]}})
               + ({3'b0, weight, 1'b0} & {36{digit[1]}})
               + ({2'b0, weight, 2'b0} & {36{digit[2]}})
               + ({1'b0, weight, 3'b0} & {36{digit[3]}});
   assign frac_sum  = 36'(frac_ff) + prod;
   assign whole_sum = 36'({whole_ff, 3'b0}) + 36'({whole_ff, 1'b0}) + 36'(digit);

   assign cnt_p1    = FPL_W'(cnt_ff) + FPL_W'(1);
   assign count_bad = eol ? (ovf_ff || (cnt_p1 != fields_per_line))
                          : (cnt_p1 >= fields_per_line);

   always_comb begin
      err_out = pend_ff;
      if ((pend_ff == ERR_NONE) && count_bad) begin
         err_out = ERR_COUNT;
      end
   end

   assign mag = (VALUE_W'(whole_ff) << FRAC_BITS) + VALUE_W'(frac_ff >> (32 - FRAC_BITS));

   always_comb begin
      result.field_index = cnt_ff;
      result.field_value = neg_ff ? -mag : mag;
      result.end_of_line = eol;
      result.error_code  = err_out;
   end

   always_comb begin
      whole_in = whole_ff;
      frac_in  = frac_ff;
      ndig_in  = ndig_ff;
      neg_in   = neg_ff;
      dot_in   = dot_ff;
      cnt_in   = cnt_ff;
      chars_in = chars_ff;
      lhb_in   = lhb_ff;
      pend_in  = pend_ff;
      ovf_in   = ovf_ff;
      if (advance) begin
         priority if (is_delim) begin
            if (emit) begin
               whole_in = '0;
               frac_in  = '0;
               ndig_in  = '0;
               neg_in   = 1'b0;
               dot_in   = 1'b0;
               chars_in = 1'b0;
               pend_in  = ERR_NONE;
               if (eol) begin
                  cnt_in = '0;
                  lhb_in = 1'b0;
                  ovf_in = 1'b0;
               end else begin
                  lhb_in = 1'b1;
                  if (count_bad) begin
                     ovf_in = 1'b1;
                  end
                  if (cnt_ff < INDEX_W'(MAX_FIELDS - 1)) begin
                     cnt_in = cnt_ff + INDEX_W'(1);
                  end
               end
            end
         end else begin
            priority if (is_digit) begin
               if (!dot_ff) begin
                  whole_in = (whole_sum > 36'(WHOLE_MAX)) ? WHOLE_MAX : whole_sum[31:0];
               end else begin
                  frac_in = (frac_sum[35:32] != 4'd0) ? 32'hFFFF_FFFF : frac_sum[31:0];
                  if (ndig_ff < NDIG_LAST) begin
                     ndig_in = ndig_ff + NDIG_W'(1);
                  end
               end
            end else if (byte_in == CH_MINUS) begin
               if (chars_ff) begin
                  if (pend_ff == ERR_NONE) pend_in = ERR_SYNTAX;
               end else begin
                  neg_in = 1'b1;
               end
            end else if (byte_in == CH_DOT) begin
               if (dot_ff) begin
                  if (pend_ff == ERR_NONE) pend_in = ERR_SYNTAX;
               end else begin
                  dot_in = 1'b1;
               end
            end else begin
               if (pend_ff == ERR_NONE) pend_in = ERR_BAD_CHAR;
            end
            chars_in = 1'b1;
            lhb_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_ff <= '0;
         frac_ff  <= '0;
         ndig_ff  <= '0;
         neg_ff   <= 1'b0;
         dot_ff   <= 1'b0;
         cnt_ff   <= '0;
         chars_ff <= 1'b0;
         lhb_ff   <= 1'b0;
         pend_ff  <= ERR_NONE;
         ovf_ff   <= 1'b0;
      end else begin
         whole_ff <= whole_in;
         frac_ff  <= frac_in;
         ndig_ff  <= ndig_in;
         neg_ff   <= neg_in;
         dot_ff   <= dot_in;
         cnt_ff   <= cnt_in;
         chars_ff <= chars_in;
         lhb_ff   <= lhb_in;
         pend_ff  <= pend_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/csvp_result_reg.sv @@
// Output register for finished fields with valid/stall handshake.
// Depends on csvp_pkg.
`default_nettype none

module csvp_result_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire csvp_pkg::result_type  result_in,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output csvp_pkg::result_type       result_out,
   output logic                       slot_free
);
   import csvp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // slot can take a new result when empty or being drained this cycle
   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign result_out = data_ff;

endmodule

`default_nettype wire

@@ rtl/core/csv_signed_decimal_field_parser.sv @@
// CSV signed decimal field parser, top level: input register, field state
// and result register. Depends on csvp_pkg, csvp_csr, csvp_field_accum, csvp_result_reg.
//
// Usage:
//  - req channel: one ASCII byte per request (req_byte_in). Comma closes a
//    field; LF or NUL closes a line. Accepted when req_valid && !req_stall.
//  - rsp channel: one response per closed field: index, signed Q32.32 value
//    (fraction width set by FRAC_BITS), end-of-line flag, error code.
//  - Path: an accepted delimiter byte goes through the input register, then
//    the field logic into the result register, where its result shows.
//  - Throughput: one byte per cycle while req_stall is low.
//  - Stall: while the result register is full and rsp_stall is high, bytes
//    that close no field keep flowing; a delimiter waits in the input
//    register and req_stall rises.
//  - Reset clears all field and line state, empties both registers and sets
//    fields_per_line to 11.
//  - fields_per_line lives at address 0 of the APB port; write it only idle.
`default_nettype none

module csv_signed_decimal_field_parser #(
   parameter int FRAC_BITS  = csvp_pkg::FRAC_BITS_DEFAULT,
   parameter int MAX_FIELDS = csvp_pkg::MAX_FIELDS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic        [csvp_pkg::BYTE_W-1:0]  req_byte_in,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic             [csvp_pkg::INDEX_W-1:0] rsp_field_index,
   output logic signed      [csvp_pkg::VALUE_W-1:0] rsp_field_value,
   output logic                                    rsp_end_of_line,
   output logic             [1:0]                  rsp_error_code,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic     [csvp_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic     [csvp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic          [csvp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                    pready
);
   import csvp_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [FPL_W-1:0]  fields_per_line;
   logic              emit, slot_free, advance;
   result_type        field_result, rsp_result;

   csvp_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .fields_per_line (fields_per_line)
   );

   // byte in the input register may go when it closes no field or the
   // result register can take its result
   assign advance   = in_valid_ff && (!emit || slot_free);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_byte_in;
      end
   end

   csvp_field_accum #(
      .FRAC_BITS  (FRAC_BITS),
      .MAX_FIELDS (MAX_FIELDS)
   ) u_accum (
      .clock           (clock),
      .reset           (reset),
      .byte_in         (in_byte_ff),
      .advance         (advance),
      .fields_per_line (fields_per_line),
      .emit            (emit),
      .result          (field_result)
   );

   csvp_result_reg u_result (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && emit),
      .result_in  (field_result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .result_out (rsp_result),
      .slot_free  (slot_free)
   );

   assign rsp_field_index = rsp_result.field_index;
   assign rsp_field_value = rsp_result.field_value;
   assign rsp_end_of_line = rsp_result.end_of_line;
   assign rsp_error_code  = 2'(rsp_result.error_code);

endmodule

`default_nettype wire
